// File: rtl/stpg_pkg.sv
// ----------------------------------------------------------------------------
// stpg_pkg: shared types and constants of the sine tone PCM generator
// Register indexes, field widths, reset values and sine table constants.
// ----------------------------------------------------------------------------
package stpg_pkg;

  // Default structural sizes.
  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int PHASE_BITS_DEF   = 32;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_BYTES_DEF    = 4;

  // Field widths of the channels and the configuration port.
  localparam int DATA_W    = 8;
  localparam int CHAN_W    = 3;
  localparam int BYTE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int INC_W     = 32;
  localparam int AMP_W     = 31;
  localparam int CCNT_W    = 4;
  localparam int SBYTES_W  = 3;
  localparam int SINE_W    = 16;
  localparam int SAMPLE_W  = 32;

  // Register reset values.
  localparam logic [INC_W-1:0]    PHASE_INC_RST = 32'd42852281;
  localparam logic [AMP_W-1:0]    AMPLITUDE_RST = 31'd16256;
  localparam logic [CCNT_W-1:0]   CHAN_CNT_RST  = 4'd2;
  localparam logic [SBYTES_W-1:0] SAMPLE_BY_RST = 3'd2;

  // Sine table construction: pi/2 and 1.0 in Q30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'd1073741824;
  localparam int              SINE_PEAK   = 32767;

  // Sample queue between the arithmetic pipeline and the byte serializer.
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC  = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_CHAN_COUNT = 2'd2,
    REG_SAMPLE_BY  = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/stpg_in_if.sv
// ----------------------------------------------------------------------------
// stpg_in_if: tick channel of the sine tone PCM generator
// Valid/ready channel carrying the restart flag of one sample tick.
// ----------------------------------------------------------------------------
interface stpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// File: rtl/stpg_out_if.sv
// ----------------------------------------------------------------------------
// stpg_out_if: byte channel of the sine tone PCM generator
// Valid/ready channel carrying one PCM byte with its position tags.
// ----------------------------------------------------------------------------
interface stpg_out_if import stpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [CHAN_W-1:0] channel_index;
  logic [BYTE_W-1:0] byte_index;
  logic              last;

  modport source (output valid, output data_byte, output channel_index,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input data_byte, input channel_index,
                  input byte_index, input last, output ready);
endinterface

// File: rtl/sine_tone_pcm_generator_unit.sv
// ----------------------------------------------------------------------------
// sine_tone_pcm_generator_unit: direct digital synthesis PCM byte source
// Phase accumulator, sine ROM lookup, amplitude scaling and little-endian
// byte serialization for every configured channel.
// ----------------------------------------------------------------------------
//
//  port      | dir | handshake      | payload
//  ----------+-----+----------------+--------------------------------------
//  in_chan   | in  | valid / ready  | restart
//  out_chan  | out | valid / ready  | data_byte, channel_index, byte_index, last
//  cfg_*     | in  | cfg_we         | cfg_index, cfg_wdata
//
//  Path: a tick passes the index register, the ROM register, the product register,
//  the sample queue and its head register before its bytes reach the output register.
//  Throughput: one byte per cycle while out_chan is ready, so a tick yields
//  channel_count * sample_bytes bytes (1 to 32) from the byte serializer.
//  Up to 8 ticks are held in flight (pipeline plus sample queue); in_chan.ready
//  drops only when all 8 slots are taken, so ticks stream in while bytes drain.
//  Reset (rst_n low, synchronous): clears phase, credit, registers to defaults,
//  queue, pipeline and output valids and the byte position. A stalled out_chan holds
//  its byte; the pipeline never stalls.
module sine_tone_pcm_generator_unit import stpg_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PHASE_BITS   = PHASE_BITS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_BYTES    = MAX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  stpg_in_if.sink              in_chan,
  stpg_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Phase to table index: keep the top 32 phase bits at most, scale by depth.
  localparam int SHIFT  = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
  localparam int PIDX_W = PHASE_BITS - SHIFT;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int DEP_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W = PIDX_W + DEP_W;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MAG_W  = SINE_W - 1;

  // Taylor series divisors (2n)(2n+1) for n = 1..9.
  localparam longint unsigned TAYLOR_DIV [9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  typedef logic signed [SINE_W-1:0] rom_t [TABLE_DEPTH];

  // Elaboration-time sine table: quarter-wave fold, Q30 Taylor sine, Q1.15 round.
  function automatic rom_t build_rom();
    rom_t              tab;
    longint unsigned   q, quad, r, x, x2, term;
    longint            sum, v;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      q    = 64'(k) * 64'd4;
      quad = q / TABLE_DEPTH;
      r    = q % TABLE_DEPTH;
      if (quad[0]) begin
        r = 64'(TABLE_DEPTH) - r;
      end
      x    = (r * HALF_PI_Q30) / TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      v = (sum * SINE_PEAK + ONE_Q30 / 2) >>> 30;
      if (v > SINE_PEAK) begin
        v = SINE_PEAK;
      end
      tab[k] = quad[1] ? SINE_W'(-v) : SINE_W'(v);
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [INC_W-1:0]    phase_inc_r;
  logic [AMP_W-1:0]    amplitude_r;
  logic [CCNT_W-1:0]   chan_cnt_r;
  logic [SBYTES_W-1:0] sample_by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= PHASE_INC_RST;
      amplitude_r <= AMPLITUDE_RST;
      chan_cnt_r  <= CHAN_CNT_RST;
      sample_by_r <= SAMPLE_BY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PHASE_INC:  phase_inc_r <= cfg_wdata[INC_W-1:0];
        REG_AMPLITUDE:  amplitude_r <= cfg_wdata[AMP_W-1:0];
        REG_CHAN_COUNT: chan_cnt_r  <= cfg_wdata[CCNT_W-1:0];
        REG_SAMPLE_BY:  sample_by_r <= cfg_wdata[SBYTES_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Credit: ticks in flight from transfer until their last byte is loaded
  // --------------------------------------------------------------------------
  logic [Q_CNT_W-1:0] inflight_r;
  logic               in_fire;
  logic               pop;

  assign in_chan.ready = (inflight_r != Q_CNT_W'(Q_DEPTH));
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + Q_CNT_W'(in_fire) - Q_CNT_W'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: phase accumulator and table index
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_used;
  logic [PHASE_BITS-1:0] inc_ext;
  logic [PIDX_W-1:0]     phase_top;
  logic [PROD_W-1:0]     idx_prod;
  logic [IDX_W-1:0]      idx_r;
  logic                  s1_v_r;

  assign inc_ext    = PHASE_BITS'(phase_inc_r);
  assign phase_used = in_chan.restart ? '0 : phase_r;
  assign phase_top  = phase_used[PHASE_BITS-1 -: PIDX_W];
  assign idx_prod   = PROD_W'(phase_top) * PROD_W'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      if (in_fire) begin
        // advance from the (possibly cleared) phase used by this tick
        phase_r <= phase_used + inc_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r <= idx_prod[PIDX_W +: IDX_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sine ROM read (registered)
  // --------------------------------------------------------------------------
  logic signed [SINE_W-1:0] rom_q;
  logic                     s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      rom_q <= SINE_ROM[idx_r];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitude times amplitude, truncated toward zero
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]         rom_abs;
  logic [MAG_W+AMP_W-1:0]   amp_prod;
  logic [AMP_W-1:0]         mag_r;
  logic                     neg_r;
  logic                     s3_v_r;

  assign rom_abs  = rom_q[SINE_W-1] ? MAG_W'(-rom_q) : rom_q[MAG_W-1:0];
  assign amp_prod = (MAG_W+AMP_W)'(rom_abs) * (MAG_W+AMP_W)'(amplitude_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      mag_r <= amp_prod[MAG_W +: AMP_W];
      neg_r <= rom_q[SINE_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Sample queue: apply the sign and push; credit guarantees room
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] q_mem [Q_DEPTH];
  logic [SAMPLE_W-1:0] sample_w;
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  q_cnt_r;
  logic [SAMPLE_W-1:0] head_r;

  assign sample_w   = neg_r ? (SAMPLE_W'(0) - SAMPLE_W'(mag_r)) : SAMPLE_W'(mag_r);
  assign rd_ptr_nxt = pop ? (rd_ptr_r + Q_PTR_W'(1)) : rd_ptr_r;

  // push, and read the next head entry; forward a push into that entry
  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      q_mem[wr_ptr_r] <= sample_w;
    end
    if (s3_v_r && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= sample_w;
    end else begin
      head_r <= q_mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (s3_v_r) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + Q_CNT_W'(s3_v_r) - Q_CNT_W'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Byte serializer: walk channels and bytes of the head sample
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]     last_ch;
  logic [BYTE_W-1:0]   last_by;
  logic [CH_W-1:0]     ch_r;
  logic [BYTE_W-1:0]   by_r;
  logic [DATA_W-1:0]   head_byte;
  logic                load;
  logic                by_end;
  logic                tick_end;
  logic [CH_W+2:0]     ch_wide;

  // clamp channel count and byte count into 1..MAX; keep the last position
  always_comb begin
    if (chan_cnt_r == '0) begin
      last_ch = '0;
    end else if (32'(chan_cnt_r) > MAX_CHANNELS) begin
      last_ch = CH_W'(MAX_CHANNELS - 1);
    end else begin
      last_ch = CH_W'(chan_cnt_r - CCNT_W'(1));
    end
    if (sample_by_r == '0) begin
      last_by = '0;
    end else if (32'(sample_by_r) > MAX_BYTES) begin
      last_by = BYTE_W'(MAX_BYTES - 1);
    end else begin
      last_by = BYTE_W'(sample_by_r - SBYTES_W'(1));
    end
  end

  assign by_end   = (by_r == last_by);
  assign tick_end = by_end && (ch_r == last_ch);
  assign load     = (q_cnt_r != '0) && (!out_chan.valid || out_chan.ready);
  assign pop      = load && tick_end;
  assign ch_wide  = (CH_W+3)'(ch_r);

  always_comb begin
    unique case (by_r)
      2'd0: head_byte = head_r[7:0];
      2'd1: head_byte = head_r[15:8];
      2'd2: head_byte = head_r[23:16];
      2'd3: head_byte = head_r[31:24];
    endcase
  end

  logic              out_v_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CHAN_W-1:0] out_ch_r;
  logic [BYTE_W-1:0] out_by_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      ch_r    <= '0;
      by_r    <= '0;
    end else begin
      if (load) begin
        out_v_r <= 1'b1;
        // advance byte, then channel; wrap both when the tick is done
        if (tick_end) begin
          ch_r <= '0;
          by_r <= '0;
        end else if (by_end) begin
          ch_r <= ch_r + CH_W'(1);
          by_r <= '0;
        end else begin
          by_r <= by_r + BYTE_W'(1);
        end
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= head_byte;
      out_ch_r   <= ch_wide[CHAN_W-1:0];
      out_by_r   <= by_r;
      out_last_r <= tick_end;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.data_byte     = out_data_r;
  assign out_chan.channel_index = out_ch_r;
  assign out_chan.byte_index    = out_by_r;
  assign out_chan.last          = out_last_r;

`ifndef SYNTHESIS
  // the queue only holds ticks that are already counted in flight
  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= inflight_r)
    else $error("sample queue holds more ticks than are in flight");

  // nothing in flight means an empty pipeline and queue
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == '0) |-> (!s1_v_r && !s2_v_r && !s3_v_r && q_cnt_r == '0))
    else $error("pipeline or queue busy with no tick in flight");

  // a restarting tick leaves the phase at one increment from zero
  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.restart) |=> (phase_r == $past(inc_ext)))
    else $error("phase after restart is not the increment");
`endif

endmodule

// File: test/tb_sine_tone_pcm_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_tone_pcm_generator_unit: self-checking bench of the DDS PCM source
// Sends sample ticks with random gaps and drains the byte stream under random
// back-pressure. An in-bench phase accumulator and sine ROM predict every PCM
// byte. Directed tests cover reset defaults, size clamping, amplitude and
// phase step extremes. Random phases follow, each with its own register set.
// ----------------------------------------------------------------------------
module tb_sine_tone_pcm_generator_unit;
  import stpg_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int PHASE_BITS   = PHASE_BITS_DEF;
  localparam int MAX_CH       = MAX_CHANNELS_DEF;
  localparam int MAX_BY       = MAX_BYTES_DEF;
  localparam int DRAIN_CYCLES = 8;     // settle time after the last byte
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int REPORT_MAX   = 10;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_TICKS  = 30;

  // One PCM byte as it leaves the block.
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [CHAN_W-1:0] chan;
    logic [BYTE_W-1:0] pos;
    logic              last;
  } pcm_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  stpg_in_if  in_ch ();
  stpg_out_if out_ch ();

  sine_tone_pcm_generator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock, 12 ns period.
  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Shadow copy of the block: registers, phase and the Q1.15 sine ROM.
  logic [INC_W-1:0]      inc_reg;
  logic [AMP_W-1:0]      amp_reg;
  logic [CCNT_W-1:0]     ccnt_reg;
  logic [SBYTES_W-1:0]   sbytes_reg;
  logic [PHASE_BITS-1:0] phase_acc;
  int                    sine_rom [TABLE_DEPTH];

  pcm_byte_t pending_bytes [$];   // predicted bytes, oldest first
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        stall_left;
  bit        in_gap_en;
  bit        out_stall_en;

  // Taylor series of sin up to x^19, all in Q30, for 0 <= x <= pi/2.
  function automatic longint sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0)       sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // Fold each entry into the first quarter turn, round to 32767 full scale and
  // apply the sign of the quadrant.
  function automatic void build_sine_rom();
    longint unsigned q;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint          v;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      q    = longint'(k) * 4;
      quad = q / TABLE_DEPTH;
      r    = q % TABLE_DEPTH;
      if (quad[0]) r = TABLE_DEPTH - r;
      x = (r * HALF_PI_Q30) / TABLE_DEPTH;
      v = (sine_q30(x) * SINE_PEAK + ONE_Q30 / 2) >>> 30;
      if (v > SINE_PEAK) v = SINE_PEAK;
      sine_rom[k] = quad[1] ? -int'(v) : int'(v);
    end
  endfunction

  // Form one tick's sample from the shadow state, queue its bytes for every
  // channel, then advance the phase.
  function automatic void predict_tick(logic restart);
    longint unsigned idx;
    int              t;
    int              t_abs;
    longint unsigned mag;
    logic [63:0]     smp;
    int              nch;
    int              nby;
    pcm_byte_t       pb;
    if (restart) phase_acc = '0;
    idx = (longint'(phase_acc) * TABLE_DEPTH) >> PHASE_BITS;
    if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
    t     = sine_rom[idx];
    t_abs = (t < 0) ? -t : t;
    mag   = (longint'(t_abs) * longint'(amp_reg)) >> 15;
    smp   = (t < 0) ? -mag : mag;
    // Zero sizes act as one, oversize values saturate.
    nch = (ccnt_reg == 0) ? 1 : (ccnt_reg > MAX_CH) ? MAX_CH : int'(ccnt_reg);
    nby = (sbytes_reg == 0) ? 1 : (sbytes_reg > MAX_BY) ? MAX_BY : int'(sbytes_reg);
    for (int c = 0; c < nch; c++) begin
      for (int b = 0; b < nby; b++) begin
        pb.data_byte = smp[8 * b +: 8];
        pb.chan      = c[CHAN_W-1:0];
        pb.pos       = b[BYTE_W-1:0];
        pb.last      = (c == nch - 1) && (b == nby - 1);
        pending_bytes.push_back(pb);
      end
    end
    phase_acc = phase_acc + inc_reg;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Compare one transferred byte against the oldest prediction.
  task automatic check_byte();
    pcm_byte_t want;
    pcm_byte_t seen;
    seen = '{out_ch.data_byte, out_ch.channel_index, out_ch.byte_index, out_ch.last};
    if (pending_bytes.size() == 0) begin
      if (mismatches < REPORT_MAX)
        $display("%0t: unexpected byte data=%02h ch=%0d pos=%0d last=%0b", $realtime,
                 seen.data_byte, seen.chan, seen.pos, seen.last);
      mismatches++;
    end else begin
      want = pending_bytes.pop_front();
      if (seen.data_byte !== want.data_byte || seen.chan !== want.chan ||
          seen.pos !== want.pos || seen.last !== want.last) begin
        if (mismatches < REPORT_MAX)
          $display({"%0t: byte expected data=%02h ch=%0d pos=%0d last=%0b,",
                    " got data=%02h ch=%0d pos=%0d last=%0b"},
                   $realtime, want.data_byte, want.chan, want.pos, want.last,
                   seen.data_byte, seen.chan, seen.pos, seen.last);
        mismatches++;
      end
    end
  endtask

  // Sink side: check every transfer, then decide ready for the next cycle.
  // Stalls of random length start only while stalling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_byte();
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (out_stall_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Offer one tick after an optional gap and hold it until the transfer; the
  // prediction is made at the transfer edge. Valid stays high afterwards so
  // back-to-back ticks need no extra cycle.
  task automatic send_tick(input logic restart);
    int gap;
    gap = in_gap_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    predict_tick(restart);
  endtask

  // Drop valid, wait for every predicted byte, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it into the shadow copy, bits above the
  // field width dropped. A spacing cycle keeps cfg_we to one assignment a step.
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PHASE_INC:  inc_reg    = val[INC_W-1:0];
      REG_AMPLITUDE:  amp_reg    = val[AMP_W-1:0];
      REG_CHAN_COUNT: ccnt_reg   = val[CCNT_W-1:0];
      REG_SAMPLE_BY:  sbytes_reg = val[SBYTES_W-1:0];
      default: ;
    endcase
  endtask

  // Reset values only: restart at the first tick and again later.
  task automatic test_reset_defaults();
    in_gap_en    = 1'b0;
    out_stall_en = 1'b1;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
  endtask

  // Zero and oversize channel counts and byte widths, with junk in the
  // write data above each field.
  task automatic test_size_limits();
    int ccnts [6];
    int sbys  [6];
    ccnts = '{0, 1, 8, 15, 9, 3};
    sbys  = '{0, 1, 4, 7, 5, 3};
    in_gap_en = 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_write(REG_CHAN_COUNT, (CFG_W'($urandom) & ~CFG_W'(4'hF)) | CFG_W'(ccnts[i]));
      cfg_write(REG_SAMPLE_BY,  (CFG_W'($urandom) & ~CFG_W'(3'h7)) | CFG_W'(sbys[i]));
      send_tick(1'b0);
      drain();
    end
  endtask

  // Quarter-turn steps hit zero, the peak and the trough; full-scale amplitude
  // wraps in narrow samples; zero amplitude; a step of all ones walks backward; a zero step holds.
  task automatic test_amplitude_limits();
    in_gap_en    = 1'b0;
    out_stall_en = 1'b0;
    cfg_write(REG_PHASE_INC, 32'h4000_0000);
    cfg_write(REG_AMPLITUDE, 32'hFFFF_FFFF);
    cfg_write(REG_CHAN_COUNT, 32'd1);
    cfg_write(REG_SAMPLE_BY, 32'd4);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    drain();
    // Sample too wide for one byte: only the low byte goes out.
    cfg_write(REG_SAMPLE_BY, 32'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    cfg_write(REG_AMPLITUDE, 32'd0);
    cfg_write(REG_SAMPLE_BY, 32'd2);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
    out_stall_en = 1'b1;
    cfg_write(REG_PHASE_INC, 32'hFFFF_FFFF);
    cfg_write(REG_AMPLITUDE, 32'd32767);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
    cfg_write(REG_PHASE_INC, 32'd0);
    send_tick(1'b0);
    drain();
  endtask

  // Random register sets, one per phase, each followed by a run of ticks with
  // occasional restarts. Some phases run without any idling.
  task automatic test_random_phases();
    int mode;
    logic [CFG_W-1:0] val;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 2))
        0:       val = $urandom;
        1:       val = $urandom_range(0, 32'h0100_0000);
        default: val = $urandom | 32'hFF00_0000;
      endcase
      cfg_write(REG_PHASE_INC, val);
      case ($urandom_range(0, 2))
        0:       val = $urandom_range(0, 32767);
        1:       val = $urandom_range(0, 32'h0001_FFFF);
        default: val = $urandom;
      endcase
      cfg_write(REG_AMPLITUDE, val);
      cfg_write(REG_CHAN_COUNT, (CFG_W'($urandom) & ~CFG_W'(4'hF)) |
                                CFG_W'($urandom_range(0, 15)));
      cfg_write(REG_SAMPLE_BY, (CFG_W'($urandom) & ~CFG_W'(3'h7)) |
                               CFG_W'($urandom_range(0, 7)));
      mode         = $urandom_range(0, 3);
      in_gap_en    = (mode == 1) || (mode == 3);
      out_stall_en = (mode == 2) || (mode == 3);
      for (int n = 0; n < PHASE_TICKS; n++)
        send_tick($urandom_range(0, 9) == 0);
      drain();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_PHASE_INC;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    in_gap_en     = 1'b0;
    out_stall_en  = 1'b0;
    inc_reg       = PHASE_INC_RST;
    amp_reg       = AMPLITUDE_RST;
    ccnt_reg      = CHAN_CNT_RST;
    sbytes_reg    = SAMPLE_BY_RST;
    phase_acc     = '0;
    build_sine_rom();

    // Hold reset before the tests, once.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_size_limits();
    test_amplitude_limits();
    test_random_phases();

    // drain() has already waited for the last byte and the settle time.
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
